@@ design/ycbcr_to_rgb_pixel_convert_top_macros.svh @@
// Assertion macros for the YCbCr to RGB pixel converter.
// Used by ycbcr_to_rgb_pixel_convert_top; define NO_ASSERTIONS to drop them.
`ifndef YCBCR_TO_RGB_PIXEL_CONVERT_TOP_MACROS_SVH
`define YCBCR_TO_RGB_PIXEL_CONVERT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define YCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define YCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define YCC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define YCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/ycc2rgb_pkg.sv @@
// Shared types and constants of the YCbCr to RGB pixel converter.
// No dependencies.
package ycc2rgb_pkg;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        ORDER_ARGB = 2'd0,
        ORDER_ABGR = 2'd1,
        ORDER_RGBA = 2'd2,
        ORDER_BGRA = 2'd3
    } t_byte_order;

    localparam int unsigned COEF_CR_R_Q16 = 91915;
    localparam int unsigned COEF_CR_G_Q16 = 46818;
    localparam int unsigned COEF_CB_G_Q16 = 22526;
    localparam int unsigned COEF_CB_B_Q16 = 115992;
    localparam int unsigned COEF_REF_FRAC = 16;

    localparam int unsigned SAMPLE_W = 13;
    localparam t_byte       ALPHA    = 8'hFF;

endpackage

@@ design/ycc2rgb_clamp.sv @@
// Channel back-conversion: fixed-point accumulator to a clamped 8-bit value.
// Depends on ycc2rgb_pkg.
module ycc2rgb_clamp
    import ycc2rgb_pkg::*;
#(
    parameter int ACC_W     = 34,
    parameter int FRAC_BITS = 16
) (
    input  logic signed [ACC_W-1:0] i_acc,
    output t_byte                   o_byte
);

    // acc >>> FRAC_BITS, keep 16 bits, >>> 5: bits [FRAC_BITS+15:FRAC_BITS+5]
    logic signed [10:0] w_chan;

    assign w_chan = i_acc[FRAC_BITS+15:FRAC_BITS+5];

    always_comb begin
        if (w_chan[10]) begin
            o_byte = 8'd0;
        end else if (w_chan[9:8] != 2'b00) begin
            o_byte = 8'hFF;
        end else begin
            o_byte = w_chan[7:0];
        end
    end

endmodule

@@ design/ycbcr_to_rgb_pixel_convert_top.sv @@
// Top level of the YCbCr to RGB pixel converter: stream in, stream out.
// Depends on ycc2rgb_pkg, ycc2rgb_clamp and the assertion macro header.
//
// One pixel of signed 8.5 Y, Cb, Cr enters per transaction and leaves as
// four bytes (R, G, B and alpha 0xFF) in the order set by the byte_order
// register. Throughput is one pixel per clock while the output is not stalled.
// The pipeline has three register stages (input register, product register,
// output register): o_m_axis_tvalid is driven by the output register, so a
// pixel passes the input and product registers before it is offered. Each
// stage holds while the next is full and stalled, so the input side keeps
// taking pixels while bubbles remain in the pipeline.
// byte_order is to be written only while the pipeline is empty.
`include "ycbcr_to_rgb_pixel_convert_top_macros.svh"

module ycbcr_to_rgb_pixel_convert_top
    import ycc2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [12:0] luma, [25:13] chroma_blue, [38:26] chroma_red, [39] zero
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3
    output logic [31:0] o_m_axis_tdata
);

    localparam int COEF_W = FRAC_BITS + 2;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = FRAC_BITS + 18;
    localparam int SHIFT  = COEF_REF_FRAC - FRAC_BITS;

    localparam logic signed [COEF_W-1:0] C_CR_R = COEF_W'(COEF_CR_R_Q16 >> SHIFT);
    localparam logic signed [COEF_W-1:0] C_CR_G = COEF_W'(COEF_CR_G_Q16 >> SHIFT);
    localparam logic signed [COEF_W-1:0] C_CB_G = COEF_W'(COEF_CB_G_Q16 >> SHIFT);
    localparam logic signed [COEF_W-1:0] C_CB_B = COEF_W'(COEF_CB_B_Q16 >> SHIFT);

    t_byte_order r_byte_order;

    logic w_adv1, w_adv2, w_adv3;

    logic                        r_vld1;
    logic signed [SAMPLE_W-1:0]  r_luma, r_cb, r_cr;

    logic                        r_vld2;
    logic [SAMPLE_W-1:0]         r_y;
    logic signed [PROD_W-1:0]    r_p_crr, r_p_crg, r_p_cbg, r_p_cbb;
    logic signed [PROD_W-1:0]    n_p_crr, n_p_crg, n_p_cbg, n_p_cbb;

    logic                        r_vld3;
    logic [31:0]                 r_tdata;
    logic [31:0]                 n_tdata;

    logic signed [ACC_W-1:0]     w_y_acc, w_crr, w_crg, w_cbg, w_cbb;
    logic signed [ACC_W-1:0]     w_acc_r, w_acc_g, w_acc_b;
    t_byte                       w_r, w_g, w_b;

    // stall chain
    assign w_adv3 = !r_vld3 || i_m_axis_tready;
    assign w_adv2 = !r_vld2 || w_adv3;
    assign w_adv1 = !r_vld1 || w_adv2;

    assign o_s_axis_tready = w_adv1;
    assign o_m_axis_tvalid = r_vld3;
    assign o_m_axis_tdata  = r_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= ORDER_ARGB;
        end else if (i_cfg_wr_en) begin
            r_byte_order <= t_byte_order'(i_cfg_wr_data);
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (w_adv1) begin
            r_vld1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_s_axis_tvalid) begin
            r_luma <= i_s_axis_tdata[12:0];
            r_cb   <= i_s_axis_tdata[25:13];
            r_cr   <= i_s_axis_tdata[38:26];
        end
    end

    // stage 2: constant products; luma + 4096 is luma with its sign bit flipped
    assign n_p_crr = r_cr * C_CR_R;
    assign n_p_crg = r_cr * C_CR_G;
    assign n_p_cbg = r_cb * C_CB_G;
    assign n_p_cbb = r_cb * C_CB_B;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (w_adv2) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_vld1) begin
            r_y     <= {~r_luma[SAMPLE_W-1], r_luma[SAMPLE_W-2:0]};
            r_p_crr <= n_p_crr;
            r_p_crg <= n_p_crg;
            r_p_cbg <= n_p_cbg;
            r_p_cbb <= n_p_cbb;
        end
    end

    // stage 3: sums, clamp, byte order
    assign w_y_acc = {{(ACC_W-SAMPLE_W-FRAC_BITS){1'b0}}, r_y, {FRAC_BITS{1'b0}}};
    assign w_crr   = {{(ACC_W-PROD_W){r_p_crr[PROD_W-1]}}, r_p_crr};
    assign w_crg   = {{(ACC_W-PROD_W){r_p_crg[PROD_W-1]}}, r_p_crg};
    assign w_cbg   = {{(ACC_W-PROD_W){r_p_cbg[PROD_W-1]}}, r_p_cbg};
    assign w_cbb   = {{(ACC_W-PROD_W){r_p_cbb[PROD_W-1]}}, r_p_cbb};

    assign w_acc_r = w_y_acc + w_crr;
    assign w_acc_g = w_y_acc - w_cbg - w_crg;
    assign w_acc_b = w_y_acc + w_cbb;

    ycc2rgb_clamp #(.ACC_W(ACC_W), .FRAC_BITS(FRAC_BITS)) u_clamp_r (
        .i_acc  (w_acc_r),
        .o_byte (w_r)
    );

    ycc2rgb_clamp #(.ACC_W(ACC_W), .FRAC_BITS(FRAC_BITS)) u_clamp_g (
        .i_acc  (w_acc_g),
        .o_byte (w_g)
    );

    ycc2rgb_clamp #(.ACC_W(ACC_W), .FRAC_BITS(FRAC_BITS)) u_clamp_b (
        .i_acc  (w_acc_b),
        .o_byte (w_b)
    );

    always_comb begin
        case (r_byte_order)
            ORDER_ARGB: begin
                n_tdata = {w_b, w_g, w_r, ALPHA};
            end
            ORDER_ABGR: begin
                n_tdata = {w_r, w_g, w_b, ALPHA};
            end
            ORDER_RGBA: begin
                n_tdata = {ALPHA, w_b, w_g, w_r};
            end
            default: begin
                n_tdata = {ALPHA, w_r, w_g, w_b};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (w_adv3) begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_vld2) begin
            r_tdata <= n_tdata;
        end
    end

    `YCC_ASSERT_NEXT(a_in_to_stage1, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_vld1)
    `YCC_ASSERT_NEXT(a_stage2_holds, i_clk, i_rst_n, r_vld2 && !w_adv3, r_vld2 && r_vld3)
    `YCC_ASSERT_SAME(a_alpha_low, i_clk, i_rst_n, r_vld3 && (r_byte_order == ORDER_ARGB || r_byte_order == ORDER_ABGR), r_tdata[7:0] == ALPHA)
    `YCC_ASSERT_SAME(a_alpha_high, i_clk, i_rst_n, r_vld3 && (r_byte_order == ORDER_RGBA || r_byte_order == ORDER_BGRA), r_tdata[31:24] == ALPHA)

endmodule
